// ----- rtl/core/exp_golomb_syntax_decoder_assert.svh -----
`ifndef EXP_GOLOMB_SYNTAX_DECODER_ASSERT_SVH
`define EXP_GOLOMB_SYNTAX_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define EGSD_ASSERT_IMPL(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |-> (rhs)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define EGSD_ASSERT_NEXT(label, lhs, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (lhs) |=> (rhs)) \
      else $error(msg);

`endif

// ----- rtl/core/egsd_pkg.sv -----
package egsd_pkg;

   localparam int MAX_LEADING_ZEROS = 32;
   localparam int CODE_W = 33;
   localparam int VALUE_W = 34;

   typedef enum logic [1:0] {
      OP_UE = 2'd0,
      OP_SE = 2'd1,
      OP_ME = 2'd2,
      OP_TE = 2'd3
   } op_type;

   typedef struct packed {
      logic       bit_req;
      logic [1:0] operation;
      logic       is_intra;
      logic [4:0] te_range;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      error;
   } rsp_payload_type;

   localparam logic [5:0] CBP48_INTRA [48] = '{
      6'd47, 6'd31, 6'd15, 6'd0,  6'd23, 6'd27, 6'd29, 6'd30,
      6'd7,  6'd11, 6'd13, 6'd14, 6'd39, 6'd43, 6'd45, 6'd46,
      6'd16, 6'd3,  6'd5,  6'd10, 6'd12, 6'd19, 6'd21, 6'd26,
      6'd28, 6'd35, 6'd37, 6'd42, 6'd44, 6'd1,  6'd2,  6'd4,
      6'd8,  6'd17, 6'd18, 6'd20, 6'd24, 6'd6,  6'd9,  6'd22,
      6'd25, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41};

   localparam logic [5:0] CBP48_INTER [48] = '{
      6'd0,  6'd16, 6'd1,  6'd2,  6'd4,  6'd8,  6'd32, 6'd3,
      6'd5,  6'd10, 6'd12, 6'd15, 6'd47, 6'd7,  6'd11, 6'd13,
      6'd14, 6'd6,  6'd9,  6'd31, 6'd35, 6'd37, 6'd42, 6'd44,
      6'd33, 6'd34, 6'd36, 6'd40, 6'd39, 6'd43, 6'd45, 6'd46,
      6'd17, 6'd18, 6'd20, 6'd24, 6'd19, 6'd21, 6'd26, 6'd28,
      6'd23, 6'd27, 6'd29, 6'd30, 6'd22, 6'd25, 6'd38, 6'd41};

   localparam logic [3:0] CBP16_INTRA [16] = '{
      4'd15, 4'd0, 4'd7, 4'd11, 4'd13, 4'd14, 4'd3, 4'd5,
      4'd10, 4'd12, 4'd1, 4'd2, 4'd4, 4'd8, 4'd6, 4'd9};

   localparam logic [3:0] CBP16_INTER [16] = '{
      4'd0, 4'd1, 4'd2, 4'd4, 4'd8, 4'd3, 4'd5, 4'd10,
      4'd12, 4'd15, 4'd7, 4'd11, 4'd13, 4'd14, 4'd6, 4'd9};

   function automatic logic [5:0] cbp48_lookup(logic intra, logic [5:0] idx);
      logic [5:0] result;
      result = '0;
      if (idx < 6'd48) begin
         result = intra ? CBP48_INTRA[idx] : CBP48_INTER[idx];
      end
      return result;
   endfunction

   function automatic logic [5:0] cbp16_lookup(logic intra, logic [3:0] idx);
      logic [3:0] result;
      result = intra ? CBP16_INTRA[idx] : CBP16_INTER[idx];
      return {2'b00, result};
   endfunction

endpackage

// ----- rtl/core/exp_golomb_syntax_decoder.sv -----
// Exp-Golomb syntax element decoder (ue, se, me, te), one bitstream bit per
// transfer on the req_ channel. Each req_ transfer carries one bit plus the
// element kind, intra flag and te range, which are sampled on the first bit
// of an element only. A transfer that completes an element (or hits more
// than 32 leading zeros) produces one rsp_ transfer with the value and an
// error flag; other transfers produce nothing.
// Throughput: one bit per cycle while results are taken. The result of the bit
// that completes an element is valid on rsp_ in the cycle after its transfer.
// The decode state and the rsp_ output register are the only stages; all
// prefix counting, suffix shifting and table mapping sit between them.
// When rsp_ready is low with a result waiting, req_ready drops until the
// result is taken; a result taken in the same cycle lets a new bit in.
// csr_ writes set chroma_format_type and are always ready; write only while
// the decoder is idle between elements.
// Synchronous reset clears the decode state, empties the output register
// and returns chroma_format_type to 1.
module exp_golomb_syntax_decoder
   import egsd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_data
);

   logic [1:0]      chroma_ff, chroma_in;
   logic            in_suffix_ff, in_suffix_in;
   logic [5:0]      zero_count_ff, zero_count_in;
   logic [5:0]      suffix_left_ff, suffix_left_in;
   logic [31:0]     suffix_accum_ff, suffix_accum_in;
   op_type          held_kind_ff, held_kind_in;
   logic            held_intra_ff, held_intra_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic              req_xfer;
   logic              start;
   op_type            kind;
   logic              intra;
   logic [31:0]       acc_shift;
   logic [31:0]       fin_acc;
   logic [CODE_W-1:0] code_plus1;
   logic [CODE_W-1:0] code;
   logic [31:0]       mag;
   logic [VALUE_W-1:0] mag_ext;
   logic [5:0]        zc_inc;
   logic              table48;
   logic              emit;
   rsp_payload_type   result;
   rsp_payload_type   finish_result;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign start     = !in_suffix_ff && (zero_count_ff == 6'd0);
   assign kind      = start ? op_type'(req_payload.operation) : held_kind_ff;
   assign intra     = start ? req_payload.is_intra : held_intra_ff;
   assign acc_shift = {suffix_accum_ff[30:0], req_payload.bit_req};
   assign fin_acc   = in_suffix_ff ? acc_shift : 32'd0;
   assign code_plus1 = (CODE_W'(1) << zero_count_ff) | {1'b0, fin_acc};
   assign code      = code_plus1 - CODE_W'(1);
   assign mag       = code_plus1[CODE_W-1:1];
   assign mag_ext   = {2'b00, mag};
   assign zc_inc    = zero_count_ff + 6'd1;
   assign table48   = (chroma_ff == 2'd1) || (chroma_ff == 2'd2);

   always_comb begin
      finish_result = '0;
      case (kind)
         OP_SE: begin
            finish_result.value = code_plus1[0] ? -mag_ext : mag_ext;
         end
         OP_ME: begin
            if (table48) begin
               if (code > CODE_W'(47)) begin
                  finish_result.error = 1'b1;
               end else begin
                  finish_result.value = VALUE_W'(cbp48_lookup(intra, code[5:0]));
               end
            end else begin
               if (code > CODE_W'(15)) begin
                  finish_result.error = 1'b1;
               end else begin
                  finish_result.value = VALUE_W'(cbp16_lookup(intra, code[3:0]));
               end
            end
         end
         default: begin
            finish_result.value = {1'b0, code};
         end
      endcase
   end

   always_comb begin
      in_suffix_in    = in_suffix_ff;
      zero_count_in   = zero_count_ff;
      suffix_left_in  = suffix_left_ff;
      suffix_accum_in = suffix_accum_ff;
      held_kind_in    = held_kind_ff;
      held_intra_in   = held_intra_ff;
      emit            = 1'b0;
      result          = '0;
      if (req_xfer) begin
         if (start) begin
            held_kind_in  = kind;
            held_intra_in = intra;
         end
         if (start && kind == OP_TE && req_payload.te_range == 5'd0) begin
            emit = 1'b1;
         end else if (start && kind == OP_TE && req_payload.te_range == 5'd1) begin
            emit = 1'b1;
            result.value = VALUE_W'(!req_payload.bit_req);
         end else if (!in_suffix_ff) begin
            if (!req_payload.bit_req) begin
               zero_count_in = zc_inc;
               if (zc_inc > 6'(MAX_LEADING_ZEROS)) begin
                  emit = 1'b1;
                  result.error = 1'b1;
               end
            end else if (zero_count_ff == 6'd0) begin
               emit   = 1'b1;
               result = finish_result;
            end else begin
               in_suffix_in    = 1'b1;
               suffix_left_in  = zero_count_ff;
               suffix_accum_in = '0;
            end
         end else begin
            suffix_accum_in = acc_shift;
            suffix_left_in  = suffix_left_ff - 6'd1;
            if (suffix_left_ff <= 6'd1) begin
               emit   = 1'b1;
               result = finish_result;
            end
         end
         if (emit) begin
            in_suffix_in    = 1'b0;
            zero_count_in   = '0;
            suffix_left_in  = '0;
            suffix_accum_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (req_xfer && emit) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign chroma_in = (csr_valid && csr_ready) ? csr_data : chroma_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chroma_ff       <= 2'd1;
         in_suffix_ff    <= 1'b0;
         zero_count_ff   <= '0;
         suffix_left_ff  <= '0;
         suffix_accum_ff <= '0;
         held_kind_ff    <= OP_UE;
         held_intra_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         chroma_ff       <= chroma_in;
         in_suffix_ff    <= in_suffix_in;
         zero_count_ff   <= zero_count_in;
         suffix_left_ff  <= suffix_left_in;
         suffix_accum_ff <= suffix_accum_in;
         held_kind_ff    <= held_kind_in;
         held_intra_ff   <= held_intra_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

`include "exp_golomb_syntax_decoder_assert.svh"

   `EGSD_ASSERT_IMPL(a_err_value_zero, rsp_valid_ff && rsp_payload_ff.error,
      rsp_payload_ff.value == '0, "error result carries a nonzero value")
   `EGSD_ASSERT_IMPL(a_suffix_bounds, in_suffix_ff,
      (suffix_left_ff != 6'd0) && (suffix_left_ff <= zero_count_ff),
      "suffix count out of range")
   `EGSD_ASSERT_IMPL(a_prefix_bound, !in_suffix_ff,
      zero_count_ff <= 6'(MAX_LEADING_ZEROS), "leading zero count overran limit")
   `EGSD_ASSERT_NEXT(a_emit_valid, req_xfer && emit, rsp_valid_ff,
      "completed element produced no result")

endmodule

// ----- tb/exp_golomb_syntax_decoder_tb.sv -----
`timescale 1ns / 100ps

module exp_golomb_syntax_decoder_tb;
   import egsd_pkg::*;

   localparam int PERIOD = 10;
   localparam int CYCLE_LIMIT = 400000;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_valid;
   logic            csr_ready;
   logic [1:0]      csr_data;

   int cbp_wide_intra [48] = '{
      47, 31, 15, 0, 23, 27, 29, 30, 7, 11, 13, 14, 39, 43, 45, 46,
      16, 3, 5, 10, 12, 19, 21, 26, 28, 35, 37, 42, 44, 1, 2, 4,
      8, 17, 18, 20, 24, 6, 9, 22, 25, 32, 33, 34, 36, 40, 38, 41};
   int cbp_wide_inter [48] = '{
      0, 16, 1, 2, 4, 8, 32, 3, 5, 10, 12, 15, 47, 7, 11, 13,
      14, 6, 9, 31, 35, 37, 42, 44, 33, 34, 36, 40, 39, 43, 45, 46,
      17, 18, 20, 24, 19, 21, 26, 28, 23, 27, 29, 30, 22, 25, 38, 41};
   int cbp_mono_intra [16] = '{15, 0, 7, 11, 13, 14, 3, 5, 10, 12, 1, 2, 4, 8, 6, 9};
   int cbp_mono_inter [16] = '{0, 1, 2, 4, 8, 3, 5, 10, 12, 15, 7, 11, 13, 14, 6, 9};

   logic [1:0]  chroma_type = 2'd1;
   logic        dec_in_suffix = 1'b0;
   logic [5:0]  dec_zero_count = '0;
   logic [5:0]  dec_suffix_left = '0;
   logic [31:0] dec_suffix = '0;
   op_type      dec_kind = OP_UE;
   logic        dec_intra = 1'b0;

   rsp_payload_type decoded_values [$];
   rsp_payload_type oldest_value;
   int error_count = 0;
   int cycle_count = 0;
   int items_accepted = 0;
   int burst_left = 0;
   int stretch_left = 0;
   int stall_mode = 0;

   exp_golomb_syntax_decoder uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic bit close_element(input logic [63:0] val, input logic err,
                                        output rsp_payload_type res);
      res.value = val[33:0];
      res.error = err;
      dec_in_suffix = 1'b0;
      dec_zero_count = '0;
      dec_suffix_left = '0;
      dec_suffix = '0;
      return 1'b1;
   endfunction

   function automatic bit map_code(input logic [63:0] code, output rsp_payload_type res);
      logic [63:0] mag;
      mag = (code + 64'd1) >> 1;
      case (dec_kind)
         OP_SE: begin
            if (code[0]) return close_element(mag, 1'b0, res);
            return close_element(64'd0 - mag, 1'b0, res);
         end
         OP_ME: begin
            if (chroma_type == 2'd1 || chroma_type == 2'd2) begin
               if (code > 64'd47) return close_element(64'd0, 1'b1, res);
               return close_element(dec_intra ? cbp_wide_intra[code[5:0]]
                                              : cbp_wide_inter[code[5:0]], 1'b0, res);
            end
            if (code > 64'd15) return close_element(64'd0, 1'b1, res);
            return close_element(dec_intra ? cbp_mono_intra[code[3:0]]
                                           : cbp_mono_inter[code[3:0]], 1'b0, res);
         end
         default: return close_element(code, 1'b0, res);
      endcase
   endfunction

   function automatic bit decode_bit(input req_payload_type item, output rsp_payload_type res);
      int lz;
      logic [63:0] code;
      res = '0;
      if (!dec_in_suffix && dec_zero_count == 6'd0) begin
         dec_kind = op_type'(item.operation);
         dec_intra = item.is_intra;
         if (dec_kind == OP_TE && item.te_range == 5'd0)
            return close_element(64'd0, 1'b0, res);
         if (dec_kind == OP_TE && item.te_range == 5'd1)
            return close_element({63'd0, ~item.bit_req}, 1'b0, res);
      end
      if (!dec_in_suffix) begin
         if (!item.bit_req) begin
            dec_zero_count = dec_zero_count + 6'd1;
            if (dec_zero_count > MAX_LEADING_ZEROS) return close_element(64'd0, 1'b1, res);
            return 1'b0;
         end
         if (dec_zero_count == 6'd0) return map_code(64'd0, res);
         dec_in_suffix = 1'b1;
         dec_suffix_left = dec_zero_count;
         dec_suffix = '0;
         return 1'b0;
      end
      dec_suffix = {dec_suffix[30:0], item.bit_req};
      if (dec_suffix_left > 6'd0) dec_suffix_left = dec_suffix_left - 6'd1;
      if (dec_suffix_left == 6'd0) begin
         lz = (dec_zero_count > 6'd32) ? 32 : int'(dec_zero_count);
         code = (64'd1 << lz) - 64'd1 + {32'd0, dec_suffix};
         return map_code(code, res);
      end
      return 1'b0;
   endfunction

   function automatic req_payload_type pack_item(input logic b, input logic [1:0] op,
                                                 input logic intra, input logic [4:0] rng);
      req_payload_type p;
      p.bit_req = b;
      p.operation = op;
      p.is_intra = intra;
      p.te_range = rng;
      return p;
   endfunction

   function automatic req_payload_type loose_item(input logic b);
      return pack_item(b, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       5'($urandom_range(0, 31)));
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stretch_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stretch_left <= $urandom_range(4, 40);
      end else begin
         stretch_left <= stretch_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= 1'b0;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_values.size() == 0) begin
            report_mismatch($sformatf("unexpected transfer, value %0d error %0b",
                                      rsp_payload.value, rsp_payload.error));
         end else begin
            oldest_value = decoded_values.pop_front();
            if (rsp_payload.value !== oldest_value.value)
               report_mismatch($sformatf("value %0d, expected %0d",
                                         rsp_payload.value, oldest_value.value));
            if (rsp_payload.error !== oldest_value.error)
               report_mismatch($sformatf("error %0b, expected %0b",
                                         rsp_payload.error, oldest_value.error));
         end
      end
   end

   task automatic send_bit(input req_payload_type item);
      rsp_payload_type res;
      int gap;
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      items_accepted++;
      if (decode_bit(item, res)) decoded_values.push_back(res);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_element(input op_type kind, input logic intra, input logic [4:0] rng,
                               input logic [63:0] code);
      int zeros;
      logic [63:0] suffix;
      zeros = 0;
      if (kind == OP_TE && rng < 5'd2) begin
         send_bit(pack_item(code[0], kind, intra, rng));
      end else begin
         while (((code + 64'd1) >> (zeros + 1)) != 64'd0) zeros++;
         suffix = code + 64'd1 - (64'd1 << zeros);
         for (int i = 0; i < zeros; i++)
            send_bit(i == 0 ? pack_item(1'b0, kind, intra, rng) : loose_item(1'b0));
         send_bit(zeros == 0 ? pack_item(1'b1, kind, intra, rng) : loose_item(1'b1));
         for (int i = zeros - 1; i >= 0; i--)
            send_bit(loose_item(suffix[i]));
      end
   endtask

   task automatic send_zero_run(input op_type kind, input logic intra, input logic [4:0] rng);
      send_bit(pack_item(1'b0, kind, intra, rng));
      repeat (MAX_LEADING_ZEROS) send_bit(loose_item(1'b0));
   endtask

   task automatic send_random_element();
      op_type kind;
      logic intra;
      logic [4:0] rng;
      int pick;
      int zeros;
      logic [63:0] mask;
      kind = op_type'($urandom_range(0, 3));
      intra = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      rng = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd1 : 5'($urandom_range(2, 31));
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         if (kind == OP_TE && rng < 5'd2) rng = 5'($urandom_range(2, 31));
         send_zero_run(kind, intra, rng);
      end else begin
         if (pick < 60) zeros = $urandom_range(0, 2);
         else if (pick < 88) zeros = $urandom_range(3, 6);
         else zeros = $urandom_range(7, 32);
         if (kind == OP_ME && $urandom_range(0, 3) != 0) zeros = $urandom_range(0, 5);
         mask = (64'd1 << zeros) - 64'd1;
         send_element(kind, intra, rng, mask + ({$urandom, $urandom} & mask));
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (decoded_values.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic quiesce();
      while (dec_in_suffix || dec_zero_count != 6'd0)
         send_bit(loose_item(dec_in_suffix ? 1'($urandom_range(0, 1)) : 1'b1));
      wait_drained();
   endtask

   task automatic write_chroma_type(input logic [1:0] value);
      quiesce();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      chroma_type = value;
   endtask

   task automatic test_element_kinds();
      send_element(OP_UE, 1'b0, 5'd0, 64'd0);
      send_element(OP_UE, 1'b1, 5'd31, 64'd1);
      send_element(OP_SE, 1'b0, 5'd0, 64'd1);
      send_element(OP_SE, 1'b1, 5'd3, 64'd2);
      send_element(OP_SE, 1'b0, 5'd1, 64'd0);
      send_element(OP_ME, 1'b1, 5'd0, 64'd0);
      send_element(OP_ME, 1'b0, 5'd0, 64'd3);
      send_element(OP_TE, 1'b0, 5'd0, 64'd1);
      send_element(OP_TE, 1'b1, 5'd0, 64'd0);
      send_element(OP_TE, 1'b1, 5'd1, 64'd0);
      send_element(OP_TE, 1'b0, 5'd1, 64'd1);
      send_element(OP_TE, 1'b0, 5'd2, 64'd2);
      send_element(OP_TE, 1'b1, 5'd31, 64'd6);
   endtask

   task automatic test_prefix_limits();
      send_element(OP_UE, 1'b0, 5'd0, 64'h1_FFFF_FFFE);
      send_element(OP_SE, 1'b1, 5'd31, 64'h1_FFFF_FFFE);
      send_element(OP_SE, 1'b0, 5'd5, 64'h1_FFFF_FFFD);
      send_zero_run(OP_ME, 1'b1, 5'd0);
      send_zero_run(OP_TE, 1'b0, 5'd31);
   endtask

   task automatic test_cbp_tables();
      logic [63:0] codes [5];
      codes = '{64'd0, 64'd15, 64'd16, 64'd47, 64'd48};
      for (int c = 0; c < 4; c++) begin
         write_chroma_type(2'(c));
         foreach (codes[i]) begin
            send_element(OP_ME, 1'b1, 5'($urandom_range(0, 31)), codes[i]);
            send_element(OP_ME, 1'b0, 5'($urandom_range(0, 31)), codes[i]);
         end
      end
   endtask

   task automatic test_random_stream(input logic [1:0] chroma, input int item_count);
      int first;
      bit paused;
      write_chroma_type(chroma);
      first = items_accepted;
      paused = 1'b0;
      while (items_accepted - first < item_count) begin
         if ($urandom_range(0, 99) < 6) send_bit(loose_item(1'($urandom_range(0, 1))));
         else send_random_element();
         if (!paused && items_accepted - first >= item_count / 2) begin
            paused = 1'b1;
            wait_drained();
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_element_kinds();
      test_prefix_limits();
      test_cbp_tables();
      test_random_stream(2'd3, 350);
      test_random_stream(2'd0, 350);
      test_random_stream(2'd2, 350);
      test_random_stream(2'd1, 350);
      quiesce();
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/egsd_pkg.sv
rtl/core/exp_golomb_syntax_decoder.sv
tb/exp_golomb_syntax_decoder_tb.sv
